/* rtl/core/keyed_record_stack_defines.svh */
// Assertion macros for the keyed record stack.
`ifndef KEYED_RECORD_STACK_DEFINES_SVH
`define KEYED_RECORD_STACK_DEFINES_SVH

`ifndef SYNTHESIS
`define KRS_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("keyed_record_stack: assertion failed");
`define KRS_ASSERT_NEVER(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(prop)) \
    else $error("keyed_record_stack: forbidden condition seen");
`else
`define KRS_ASSERT(lbl, clk, rst_n, prop)
`define KRS_ASSERT_NEVER(lbl, clk, rst_n, prop)
`endif

`endif

/* rtl/core/krs_pkg.sv */
`timescale 1ns / 1ps

package krs_pkg;

  localparam int unsigned DepthDef       = 64;
  localparam int unsigned IdBitsDef      = 16;
  localparam int unsigned PayloadBitsDef = 32;

  localparam logic [2:0] ModePush   = 3'd0;
  localparam logic [2:0] ModePop    = 3'd1;
  localparam logic [2:0] ModeSearch = 3'd2;
  localparam logic [2:0] ModeRemove = 3'd3;
  localparam logic [2:0] ModeClear  = 3'd4;

  localparam logic [1:0] StOk      = 2'd0;
  localparam logic [1:0] StEmpty   = 2'd1;
  localparam logic [1:0] StFull    = 2'd2;
  localparam logic [1:0] StMissing = 2'd3;

endpackage

/* rtl/core/keyed_record_stack.sv */
`timescale 1ns / 1ps
// Keyed record stack: a LIFO of up to DEPTH records (id, payload) in one
// synchronous RAM, with push, pop, search by id, remove by id and clear.
// Command channel: a word (mode_i, key_id_i, record_payload_i) is taken on a
// rising edge with start_i high and busy_o low. Result channel: valid_o is
// high for exactly one cycle with status_o, out_id_o, out_payload_o, count_o
// and is_empty_o; the receiver cannot stall, so the result is simply gone
// after that cycle.
// Steps from the accepted command to its result:
//   push, clear, unused modes and any error on an empty or full stack:
//   result registered directly; pop: one RAM read of the top record
//   search: records examined from the top (1..count) until a match
//   remove: as search, then each record above the match is moved down
//   one slot.
// The RAM read/write port paces these steps: the scan compares one record
// a cycle and the gap is closed one record a cycle, so the longest remove
// is a match at the bottom. busy_o is low while idle, so
// a new command can be taken in the cycle its predecessor's result is shown.
// Reset empties the stack at once (count to zero); RAM contents are left.
`include "keyed_record_stack_defines.svh"

module keyed_record_stack
  import krs_pkg::*;
#(
  parameter int unsigned DEPTH        = DepthDef,
  parameter int unsigned ID_BITS      = IdBitsDef,
  parameter int unsigned PAYLOAD_BITS = PayloadBitsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic [2:0]                    mode_i,
  input  logic [ID_BITS-1:0]            key_id_i,
  input  logic [PAYLOAD_BITS-1:0]       record_payload_i,
  output logic                          valid_o,
  output logic [1:0]                    status_o,
  output logic [ID_BITS-1:0]            out_id_o,
  output logic [PAYLOAD_BITS-1:0]       out_payload_o,
  output logic [$clog2(DEPTH+1)-1:0]    count_o,
  output logic                          is_empty_o
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned WW = ID_BITS + PAYLOAD_BITS;
  localparam logic [CW-1:0] DepthC = CW'(DEPTH);

  typedef enum logic [1:0] {SIdle, SPopRd, SScan, SShift} state_e;

  state_e                   state_q;
  logic [CW-1:0]            count_q;
  logic [AW-1:0]            idx_q;
  logic [AW-1:0]            sh_q;
  logic [ID_BITS-1:0]       key_q;
  logic                     rm_q;
  logic                     valid_q;
  logic [1:0]               status_q;
  logic [ID_BITS-1:0]       oid_q;
  logic [PAYLOAD_BITS-1:0]  opay_q;

  logic [WW-1:0]            mem [DEPTH];
  logic [WW-1:0]            rdata_q;

  logic                     accept;
  logic                     full;
  logic                     empty;
  logic [CW-1:0]            cnt_m1;
  logic [AW-1:0]            top_addr;
  logic [ID_BITS-1:0]       rd_id;
  logic [PAYLOAD_BITS-1:0]  rd_pay;
  logic                     match;
  logic                     go_shift;
  logic                     more_shift;
  logic                     rd_en;
  logic [AW-1:0]            rd_addr;
  logic                     we;
  logic [AW-1:0]            wa;
  logic [WW-1:0]            wd;

  assign accept     = start_i && (state_q == SIdle);
  assign full       = (count_q == DepthC);
  assign empty      = (count_q == '0);
  assign cnt_m1     = count_q - CW'(1);
  assign top_addr   = cnt_m1[AW-1:0];
  assign rd_id      = rdata_q[WW-1:PAYLOAD_BITS];
  assign rd_pay     = rdata_q[PAYLOAD_BITS-1:0];
  assign match      = (rd_id == key_q);
  assign go_shift   = (CW'(idx_q) + CW'(1)) < count_q;
  assign more_shift = (CW'(sh_q) + CW'(2)) < count_q;

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = idx_q;
    we      = 1'b0;
    wa      = count_q[AW-1:0];
    wd      = {key_id_i, record_payload_i};
    case (state_q)
      SIdle: begin
        if (accept) begin
          case (mode_i)
            ModePush: we = !full;
            ModePop, ModeSearch, ModeRemove: begin
              rd_en   = !empty;
              rd_addr = top_addr;
            end
            default: ;
          endcase
        end
      end
      SScan: begin
        if (match) begin
          if (rm_q && go_shift) begin
            rd_en   = 1'b1;
            rd_addr = idx_q + AW'(1);
          end
        end else if (idx_q != '0) begin
          rd_en   = 1'b1;
          rd_addr = idx_q - AW'(1);
        end
      end
      SShift: begin
        we = 1'b1;
        wa = sh_q;
        wd = rdata_q;
        if (more_shift) begin
          rd_en   = 1'b1;
          rd_addr = sh_q + AW'(2);
        end
      end
      default: ;
    endcase
  end

  // record RAM, one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (rd_en) begin
      rdata_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= SIdle;
      count_q  <= '0;
      idx_q    <= '0;
      sh_q     <= '0;
      key_q    <= '0;
      rm_q     <= 1'b0;
      valid_q  <= 1'b0;
      status_q <= StOk;
      oid_q    <= '0;
      opay_q   <= '0;
    end else begin
      valid_q <= 1'b0;
      case (state_q)
        SIdle: begin
          if (accept) begin
            key_q  <= key_id_i;
            rm_q   <= (mode_i == ModeRemove);
            oid_q  <= '0;
            opay_q <= '0;
            case (mode_i)
              ModePush: begin
                valid_q <= 1'b1;
                if (full) begin
                  status_q <= StFull;
                end else begin
                  status_q <= StOk;
                  count_q  <= count_q + CW'(1);
                end
              end
              ModePop: begin
                if (empty) begin
                  valid_q  <= 1'b1;
                  status_q <= StEmpty;
                end else begin
                  count_q <= cnt_m1;
                  state_q <= SPopRd;
                end
              end
              ModeSearch, ModeRemove: begin
                if (empty) begin
                  valid_q  <= 1'b1;
                  status_q <= StEmpty;
                end else begin
                  idx_q   <= top_addr;
                  state_q <= SScan;
                end
              end
              ModeClear: begin
                valid_q  <= 1'b1;
                status_q <= StOk;
                count_q  <= '0;
              end
              default: begin
                valid_q  <= 1'b1;
                status_q <= StOk;
              end
            endcase
          end
        end
        SPopRd: begin
          valid_q  <= 1'b1;
          status_q <= StOk;
          oid_q    <= rd_id;
          opay_q   <= rd_pay;
          state_q  <= SIdle;
        end
        SScan: begin
          if (match) begin
            oid_q  <= rd_id;
            opay_q <= rd_pay;
            if (rm_q && go_shift) begin
              sh_q    <= idx_q;
              state_q <= SShift;
            end else begin
              valid_q  <= 1'b1;
              status_q <= StOk;
              if (rm_q) begin
                count_q <= cnt_m1;
              end
              state_q <= SIdle;
            end
          end else if (idx_q == '0) begin
            valid_q  <= 1'b1;
            status_q <= StMissing;
            state_q  <= SIdle;
          end else begin
            idx_q <= idx_q - AW'(1);
          end
        end
        SShift: begin
          if (more_shift) begin
            sh_q <= sh_q + AW'(1);
          end else begin
            valid_q  <= 1'b1;
            status_q <= StOk;
            count_q  <= cnt_m1;
            state_q  <= SIdle;
          end
        end
        default: state_q <= SIdle;
      endcase
    end
  end

  assign busy_o        = (state_q != SIdle);
  assign valid_o       = valid_q;
  assign status_o      = status_q;
  assign out_id_o      = oid_q;
  assign out_payload_o = opay_q;
  assign count_o       = count_q;
  assign is_empty_o    = empty;

  `KRS_ASSERT(a_count_bound, clk_i, rst_ni, count_q <= DepthC)
  `KRS_ASSERT(a_push_grows, clk_i, rst_ni,
              (accept && mode_i == ModePush && !full) |=> (count_q == $past(count_q) + CW'(1)))
  `KRS_ASSERT(a_err_zero, clk_i, rst_ni, (valid_q && status_q != StOk) |-> (oid_q == '0 && opay_q == '0))
  `KRS_ASSERT(a_shift_range, clk_i, rst_ni, (state_q == SShift) |-> ((CW'(sh_q) + CW'(1)) < count_q))
  `KRS_ASSERT_NEVER(a_valid_idle, clk_i, rst_ni, valid_q && busy_o)

endmodule

/* verif/keyed_record_stack_tb.sv */
`timescale 1ns / 1ps

module keyed_record_stack_tb;
  import krs_pkg::*;

  localparam int Depth = DepthDef;
  localparam logic [2:0] ModeSpareLo = 3'd5;
  localparam logic [2:0] ModeSpareHi = 3'd7;
  localparam int DirRows = 24;
  localparam int RandWords = 950;
  localparam int TailCycles = 2 * Depth + 20;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] rid;
    logic [31:0] rpay;
    logic [6:0]  cnt;
    logic        empty;
  } stack_result_t;

  localparam int ResW = $bits(stack_result_t);

  typedef struct packed {
    logic [2:0]    mode;
    logic [15:0]   key;
    logic [31:0]   pay;
    logic          typed;
    stack_result_t res;
  } stim_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start_i = 1'b0;
  logic [2:0]  mode_i = '0;
  logic [15:0] key_id_i = '0;
  logic [31:0] record_payload_i = '0;
  logic        busy_o;
  logic        valid_o;
  logic [1:0]  status_o;
  logic [15:0] out_id_o;
  logic [31:0] out_payload_o;
  logic [6:0]  count_o;
  logic        is_empty_o;

  keyed_record_stack u_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start_i          (start_i),
    .busy_o           (busy_o),
    .mode_i           (mode_i),
    .key_id_i         (key_id_i),
    .record_payload_i (record_payload_i),
    .valid_o          (valid_o),
    .status_o         (status_o),
    .out_id_o         (out_id_o),
    .out_payload_o    (out_payload_o),
    .count_o          (count_o),
    .is_empty_o       (is_empty_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // shadow copy of the stack
  logic [15:0] stk_id[Depth];
  logic [31:0] stk_pay[Depth];
  int          stk_cnt = 0;

  stack_result_t pending_q[$];
  int            fail_cnt = 0;
  int            n_words = 0;
  logic [15:0]   id_pool[8];
  bit            idle_on = 1'b1;

  function automatic stack_result_t apply_stack_op(input logic [2:0] mode,
                                                   input logic [15:0] key,
                                                   input logic [31:0] pay);
    stack_result_t r;
    int pos;
    r = '0;
    r.status = StOk;
    pos = -1;
    case (mode)
      ModePush: begin
        if (stk_cnt >= Depth) begin
          r.status = StFull;
        end else begin
          stk_id[stk_cnt] = key;
          stk_pay[stk_cnt] = pay;
          stk_cnt++;
        end
      end
      ModePop: begin
        if (stk_cnt == 0) begin
          r.status = StEmpty;
        end else begin
          stk_cnt--;
          r.rid = stk_id[stk_cnt];
          r.rpay = stk_pay[stk_cnt];
        end
      end
      ModeSearch, ModeRemove: begin
        if (stk_cnt == 0) begin
          r.status = StEmpty;
        end else begin
          for (int i = stk_cnt - 1; i >= 0; i--)
            if (pos < 0 && stk_id[i] == key) pos = i;
          if (pos < 0) begin
            r.status = StMissing;
          end else begin
            r.rid = stk_id[pos];
            r.rpay = stk_pay[pos];
            if (mode == ModeRemove) begin
              for (int j = pos; j < stk_cnt - 1; j++) begin
                stk_id[j] = stk_id[j+1];
                stk_pay[j] = stk_pay[j+1];
              end
              stk_cnt--;
            end
          end
        end
      end
      ModeClear: stk_cnt = 0;
      default: ;
    endcase
    r.cnt = 7'(stk_cnt);
    r.empty = (stk_cnt == 0);
    return r;
  endfunction

  function automatic int pick_gap();
    return idle_on ? $urandom_range(0, 18) : 0;
  endfunction

  function automatic logic [15:0] pick_key();
    if ($urandom_range(0, 4) == 0) return 16'($urandom);
    return id_pool[$urandom_range(0, 7)];
  endfunction

  // hold the word until taken, then log what should come back
  task automatic send_word(input logic [2:0] mode, input logic [15:0] key,
                           input logic [31:0] pay, input bit typed,
                           input stack_result_t typed_res);
    stack_result_t r;
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    mode_i <= mode;
    key_id_i <= key;
    record_payload_i <= pay;
    start_i <= 1'b1;
    @(posedge clk_i);
    while (busy_o !== 1'b0) @(posedge clk_i);
    r = apply_stack_op(mode, key, pay);
    pending_q.push_back(typed ? typed_res : r);
    n_words++;
  endtask

  task automatic send_rand(input logic [2:0] mode);
    send_word(mode, pick_key(), $urandom, 1'b0, '0);
  endtask

  task automatic drain_wait();
    start_i <= 1'b0;
    wait (pending_q.size() == 0);
    @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    stack_result_t got;
    stack_result_t want;
    if (rst_ni && valid_o === 1'b1) begin
      got = {status_o, out_id_o, out_payload_o, count_o, is_empty_o};
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected result: status %0d id %h payload %h count %0d empty %0b",
                 $time, got.status, got.rid, got.rpay, got.cnt, got.empty);
        fail_cnt++;
      end else begin
        want = pending_q.pop_front();
        if (got !== want) begin
          $display("%0t: mismatch: expected status %0d id %h payload %h count %0d empty %0b",
                   $time, want.status, want.rid, want.rpay, want.cnt, want.empty);
          $display("%0t:           actual status %0d id %h payload %h count %0d empty %0b",
                   $time, got.status, got.rid, got.rpay, got.cnt, got.empty);
          fail_cnt++;
        end
      end
    end
  end

  initial begin
    #20_000_000;
    $display("Verification failed");
    $finish;
  end

  initial begin
    stim_row_t dir_tab[DirRows];
    int r;
    int ep;
    int n;
    bit paused;
    logic [2:0] m;

    dir_tab[0]  = {ModePop, 16'h0000, 32'hDEAD_BEEF, 1'b1, StEmpty, 16'h0, 32'h0, 7'd0, 1'b1};
    dir_tab[1]  = {ModeSearch, 16'hFFFF, 32'h0, 1'b1, StEmpty, 16'h0, 32'h0, 7'd0, 1'b1};
    dir_tab[2]  = {ModeRemove, 16'h0000, 32'h0, 1'b1, StEmpty, 16'h0, 32'h0, 7'd0, 1'b1};
    dir_tab[3]  = {ModePush, 16'hFFFF, 32'hFFFF_FFFF, 1'b1, StOk, 16'h0, 32'h0, 7'd1, 1'b0};
    dir_tab[4]  = {ModePush, 16'h0000, 32'h0000_0000, 1'b1, StOk, 16'h0, 32'h0, 7'd2, 1'b0};
    dir_tab[5]  = {ModePush, 16'h1234, 32'hA5A5_A5A5, 1'b1, StOk, 16'h0, 32'h0, 7'd3, 1'b0};
    dir_tab[6]  = {ModePush, 16'hFFFF, 32'h5555_5555, 1'b1, StOk, 16'h0, 32'h0, 7'd4, 1'b0};
    dir_tab[7]  = {ModeSearch, 16'hFFFF, 32'h0,
                   1'b1, StOk, 16'hFFFF, 32'h5555_5555, 7'd4, 1'b0};
    dir_tab[8]  = {ModeSearch, 16'h0007, 32'h0, 1'b1, StMissing, 16'h0, 32'h0, 7'd4, 1'b0};
    dir_tab[9]  = {ModeRemove, 16'h0007, 32'h0, 1'b1, StMissing, 16'h0, 32'h0, 7'd4, 1'b0};
    dir_tab[10] = {ModeRemove, 16'hFFFF, 32'h0,
                   1'b1, StOk, 16'hFFFF, 32'h5555_5555, 7'd3, 1'b0};
    dir_tab[11] = {ModeSearch, 16'hFFFF, 32'h0,
                   1'b1, StOk, 16'hFFFF, 32'hFFFF_FFFF, 7'd3, 1'b0};
    dir_tab[12] = {ModeRemove, 16'h0000, 32'h0, 1'b1, StOk, 16'h0, 32'h0, 7'd2, 1'b0};
    dir_tab[13] = {ModePop, 16'h0000, 32'h0,
                   1'b1, StOk, 16'h1234, 32'hA5A5_A5A5, 7'd1, 1'b0};
    dir_tab[14] = {ModeSpareLo, 16'hFFFF, 32'hFFFF_FFFF,
                   1'b1, StOk, 16'h0, 32'h0, 7'd1, 1'b0};
    dir_tab[15] = {ModeSpareLo + 3'd1, 16'h0000, 32'h0,
                   1'b1, StOk, 16'h0, 32'h0, 7'd1, 1'b0};
    dir_tab[16] = {ModeSpareHi, 16'hFFFF, 32'h0, 1'b1, StOk, 16'h0, 32'h0, 7'd1, 1'b0};
    dir_tab[17] = {ModePush, 16'h8000, 32'h8000_0001, 1'b0, {ResW{1'b0}}};
    dir_tab[18] = {ModeSearch, 16'h8000, 32'h0, 1'b0, {ResW{1'b0}}};
    dir_tab[19] = {ModeClear, 16'hFFFF, 32'hFFFF_FFFF, 1'b1, StOk, 16'h0, 32'h0, 7'd0, 1'b1};
    dir_tab[20] = {ModePop, 16'h0000, 32'h0, 1'b1, StEmpty, 16'h0, 32'h0, 7'd0, 1'b1};
    dir_tab[21] = {ModePush, 16'h0000, 32'h0, 1'b1, StOk, 16'h0, 32'h0, 7'd1, 1'b0};
    dir_tab[22] = {ModeClear, 16'h0000, 32'h0, 1'b1, StOk, 16'h0, 32'h0, 7'd0, 1'b1};
    dir_tab[23] = {ModeRemove, 16'h0000, 32'h0, 1'b1, StEmpty, 16'h0, 32'h0, 7'd0, 1'b1};

    id_pool[0] = 16'h0000;
    id_pool[1] = 16'hFFFF;
    for (int i = 2; i < 8; i++) id_pool[i] = 16'($urandom);

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < DirRows; i++)
      send_word(dir_tab[i].mode, dir_tab[i].key, dir_tab[i].pay,
                dir_tab[i].typed, dir_tab[i].res);

    // first episode always fills the stack, then pushes into a full one
    ep = 0;
    paused = 1'b0;
    while (n_words < DirRows + RandWords) begin
      idle_on = ($urandom_range(0, 2) != 0);
      if (ep == 0 || ep == 1) begin
        while (stk_cnt < Depth) send_rand(ModePush);
        n = $urandom_range(1, 3);
        repeat (n) send_rand(ModePush);
        n = $urandom_range(2, 6);
        repeat (n) send_rand($urandom_range(0, 1) ? ModeSearch : ModeRemove);
      end else if (ep == 2) begin
        while (stk_cnt > 0) send_rand($urandom_range(0, 3) == 0 ? ModeRemove : ModePop);
        n = $urandom_range(1, 2);
        repeat (n) send_rand(3'($urandom_range(ModePop, ModeRemove)));
      end else begin
        repeat (40) begin
          r = $urandom_range(0, 99);
          if (r < 35) m = ModePush;
          else if (r < 50) m = ModePop;
          else if (r < 70) m = ModeSearch;
          else if (r < 90) m = ModeRemove;
          else if (r < 94) m = ModeClear;
          else if (r < 97) m = 3'($urandom_range(ModeSpareHi, ModeSpareLo));
          else m = 3'($urandom);
          send_rand(m);
        end
      end
      if (!paused || $urandom_range(0, 3) == 0) begin
        drain_wait();
        paused = 1'b1;
      end
      ep = $urandom_range(0, 9);
    end

    start_i <= 1'b0;
    wait (pending_q.size() == 0);
    repeat (TailCycles) @(posedge clk_i);
    if (fail_cnt == 0 && pending_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
